// ----- sv/triggered_channel_shuffle_assert.svh -----
// Assertion macros for the triggered channel shuffle.
// Needs clk and rst_n in the scope of the module that includes it.
`ifndef TRIGGERED_CHANNEL_SHUFFLE_ASSERT_SVH
`define TRIGGERED_CHANNEL_SHUFFLE_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcs_pkg.sv -----
// Shared constants, types and functions of the triggered channel shuffle.
// No dependencies; used by tcs_rng, tcs_slot_ram and the top level.
package tcs_pkg;

  localparam int LANES       = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int LANE_W      = $clog2(LANES);
  localparam int CNT_W       = $clog2(LANES + 1);
  localparam int CHAN_W      = 4;
  localparam int SEED_W      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = (((LANES + 1) * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [SEED_W-1:0] SEED_K1 = 32'd1243598713;
  localparam logic [SEED_W-1:0] SEED_K2 = 32'd3093459404;
  localparam logic [SEED_W-1:0] SEED_K3 = 32'd1821928721;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS_IN_USE,
    REG_RNG_SEED
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DRAW,
    S_RDK,
    S_WRJ,
    S_WRK,
    S_READ,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [SEED_W-1:0] s1;
    logic [SEED_W-1:0] s2;
    logic [SEED_W-1:0] s3;
  } rng_words_t;

  typedef struct packed {
    logic seed_we;
    logic step;
  } rng_ctl_t;

  typedef struct packed {
    logic              we;
    logic [LANE_W-1:0] waddr;
    sample_t           wdata;
    logic              re;
    logic [LANE_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [SEED_W-1:0] hash_step1(input logic [SEED_W-1:0] h);
    logic [SEED_W-1:0] t;
    t = h + ~(h << 15);
    return t ^ (t >> 10);
  endfunction

  function automatic logic [SEED_W-1:0] hash_step2(input logic [SEED_W-1:0] h);
    logic [SEED_W-1:0] t;
    t = h + (h << 3);
    return t ^ (t >> 6);
  endfunction

  function automatic logic [SEED_W-1:0] hash_step3(input logic [SEED_W-1:0] h);
    logic [SEED_W-1:0] t;
    t = h + ~(h << 11);
    return t ^ (t >> 16);
  endfunction

  function automatic rng_words_t seed_words(input logic [SEED_W-1:0] h);
    rng_words_t w;
    w.s1 = SEED_K1 ^ h;
    if (w.s1 < 32'd2) w.s1 = SEED_K1;
    w.s2 = SEED_K2 ^ h;
    if (w.s2 < 32'd8) w.s2 = SEED_K2;
    w.s3 = SEED_K3 ^ h;
    if (w.s3 < 32'd16) w.s3 = SEED_K3;
    return w;
  endfunction

  function automatic rng_words_t taus_next(input rng_words_t w);
    rng_words_t n;
    n.s1 = ((w.s1 & 32'hFFFF_FFFE) << 12) ^ (((w.s1 << 13) ^ w.s1) >> 19);
    n.s2 = ((w.s2 & 32'hFFFF_FFF8) << 4) ^ (((w.s2 << 2) ^ w.s2) >> 25);
    n.s3 = ((w.s3 & 32'hFFFF_FFF0) << 17) ^ (((w.s3 << 3) ^ w.s3) >> 11);
    return n;
  endfunction

  localparam rng_words_t RNG_RESET =
    seed_words(hash_step3(hash_step2(hash_step1(32'd1))));

endpackage

// ----- sv/tcs_rng.sv -----
// taus88 generator with a registered, stepwise seed expansion (hash_step1, hash_step2, then hash_step3).
// Depends on tcs_pkg.
module tcs_rng (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcs_pkg::rng_ctl_t         ctl,
  input  logic [tcs_pkg::SEED_W-1:0] seed,
  output logic [tcs_pkg::SEED_W-1:0] draw_o,
  output logic                      busy_o
);
  import tcs_pkg::*;

  rng_words_t        words_r, words_nxt, words_step;
  logic [SEED_W-1:0] h_r, h_nxt;
  logic [1:0]        exp_cnt_r, exp_cnt_nxt;

  assign words_step = taus_next(words_r);
  assign draw_o     = words_step.s1 ^ words_step.s2 ^ words_step.s3;
  assign busy_o     = (exp_cnt_r != 2'd0);

  always_comb begin
    words_nxt   = words_r;
    h_nxt       = h_r;
    exp_cnt_nxt = exp_cnt_r;
    if (ctl.seed_we) begin
      h_nxt       = seed;
      exp_cnt_nxt = 2'd1;
    end else begin
      case (exp_cnt_r)
        2'd1: begin
          h_nxt       = hash_step1(h_r);
          exp_cnt_nxt = 2'd2;
        end
        2'd2: begin
          h_nxt       = hash_step2(h_r);
          exp_cnt_nxt = 2'd3;
        end
        2'd3: begin
          words_nxt   = seed_words(hash_step3(h_r));
          exp_cnt_nxt = 2'd0;
        end
        default: begin
          if (ctl.step) words_nxt = words_step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r   <= RNG_RESET;
      exp_cnt_r <= 2'd0;
    end else begin
      words_r   <= words_nxt;
      exp_cnt_r <= exp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

endmodule

// ----- sv/tcs_slot_ram.sv -----
// Slot store: one write port, one registered read port, per-entry valid bits.
// Depends on tcs_pkg; an entry never written reads as zero.
module tcs_slot_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  tcs_pkg::ram_req_t req,
  output tcs_pkg::sample_t  rdata
);
  import tcs_pkg::*;

  sample_t          mem [LANES];
  logic [LANES-1:0] valid_r;
  sample_t          rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata_r <= valid_r[req.raddr] ? mem[req.raddr] : '0;
  end

endmodule

// ----- sv/triggered_channel_shuffle.sv -----
// Triggered channel shuffle: top level with the frame sequencer.
// Depends on tcs_pkg, tcs_rng, tcs_slot_ram and triggered_channel_shuffle_assert.svh.
//
// Usage:
//   in_*  : one item per audio frame, trigger then eight channel samples.
//   out_* : one item per frame, the eight held slots; unused lanes are zero.
//   cfg_* : register 0 sets channels in use (n), register 1 the generator seed.
//   A frame is taken only in idle. It loads the slot memory one lane a cycle
//   when the trigger rises or on the first frame after reset, then runs
//   Fisher-Yates swaps, n-1 of them on a rising trigger after the first frame
//   (each: one draw, read j, read k, two write-backs), and finally reads the n
//   slots back into the result and pushes it.
//   A seed write is expanded in the generator; no frame is taken meanwhile.
//   The result waits in an output register, so the next frame is taken while
//   the receiver stalls; a new result waits in the push cycle until it is free.
//   Reset: store reads as zero, the generator holds the expansion of seed 1,
//   n is eight, and the next frame loads the store unshuffled.
module triggered_channel_shuffle (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0: trigger, sample_0 .. sample_7
  input  logic [tcs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0: held_0 .. held_7
  output logic [tcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tcs_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LANE_W-1:0] j_r, j_nxt;
  logic [LANE_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SEED_W-1:0] r_r, r_nxt;
  sample_t           tmp_r, tmp_nxt;
  sample_t           samp_r [LANES];
  sample_t           samp_nxt [LANES];
  sample_t           res_r [LANES];
  sample_t           res_nxt [LANES];
  sample_t           out_r [LANES];
  sample_t           out_nxt [LANES];
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              trig_high_r, trig_high_nxt;
  logic              first_pend_r, first_pend_nxt;
  logic              shuffle_r, shuffle_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;

  rng_ctl_t          rng_ctl;
  logic              rng_seed_we;
  logic              rng_step;
  logic [SEED_W-1:0] rng_draw;
  logic              rng_busy;
  ram_req_t          ram_req;
  sample_t           ram_rdata;

  logic                    accept;
  logic [CNT_W-1:0]        n_eff;
  sample_t                 trig;
  logic                    trig_high;
  logic                    rising;
  logic [CNT_W-1:0]        m;
  logic [SEED_W+CNT_W-1:0] prod;
  logic [CNT_W-1:0]        ksum;
  logic [CNT_W-1:0]        cnt_m1;

  assign rng_ctl = '{seed_we: rng_seed_we, step: rng_step};

  tcs_rng u_rng (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rng_ctl),
    .seed   (cfg_wdata[SEED_W-1:0]),
    .draw_o (rng_draw),
    .busy_o (rng_busy)
  );

  tcs_slot_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !rng_busy;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    out_tdata = '0;
    for (int l = 0; l < LANES; l++) begin
      out_tdata[l*SAMPLE_BITS +: SAMPLE_BITS] = out_r[l];
    end
  end

  assign trig      = in_tdata[SAMPLE_BITS-1:0];
  assign trig_high = (trig != '0) && !trig[SAMPLE_BITS-1];
  assign rising    = trig_high && !trig_high_r;

  always_comb begin
    if (chan_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (chan_r > CHAN_W'(LANES)) begin
      n_eff = CNT_W'(LANES);
    end else begin
      n_eff = CNT_W'(chan_r);
    end
  end

  assign m      = n_r - CNT_W'(j_r);
  assign prod   = r_r * m;
  assign ksum   = CNT_W'(j_r) + prod[SEED_W +: CNT_W];
  assign cnt_m1 = cnt_r - CNT_W'(1);

  // configuration decode
  always_comb begin
    chan_nxt    = chan_r;
    rng_seed_we = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNELS_IN_USE: chan_nxt = cfg_wdata[CHAN_W-1:0];
        REG_RNG_SEED:        rng_seed_we = 1'b1;
        default:             chan_nxt = chan_r;
      endcase
    end
  end

  // frame sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    r_nxt          = r_r;
    tmp_nxt        = tmp_r;
    samp_nxt       = samp_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    trig_high_nxt  = trig_high_r;
    first_pend_nxt = first_pend_r;
    shuffle_nxt    = shuffle_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rng_step       = 1'b0;
    ram_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          for (int l = 0; l < LANES; l++) begin
            samp_nxt[l] = in_tdata[(l+1)*SAMPLE_BITS +: SAMPLE_BITS];
            res_nxt[l]  = '0;
          end
          n_nxt          = n_eff;
          cnt_nxt        = '0;
          shuffle_nxt    = !first_pend_r && rising;
          trig_high_nxt  = trig_high;
          first_pend_nxt = 1'b0;
          state_nxt      = (first_pend_r || rising) ? S_LOAD : S_READ;
        end
      end
      S_LOAD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r[LANE_W-1:0];
        ram_req.wdata = samp_r[cnt_r[LANE_W-1:0]];
        if (cnt_r == n_r - CNT_W'(1)) begin
          cnt_nxt = '0;
          j_nxt   = '0;
          if (shuffle_r && (n_r > CNT_W'(1))) begin
            state_nxt = S_DRAW;
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DRAW: begin
        rng_step      = 1'b1;
        r_nxt         = rng_draw;
        ram_req.re    = 1'b1;
        ram_req.raddr = j_r;
        state_nxt     = S_RDK;
      end
      S_RDK: begin
        if (ksum >= CNT_W'(LANES)) begin
          k_nxt = LANE_W'(LANES - 1);
        end else begin
          k_nxt = ksum[LANE_W-1:0];
        end
        ram_req.re    = 1'b1;
        ram_req.raddr = k_nxt;
        tmp_nxt       = ram_rdata;
        state_nxt     = S_WRJ;
      end
      S_WRJ: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = ram_rdata;
        state_nxt     = S_WRK;
      end
      S_WRK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k_r;
        ram_req.wdata = tmp_r;
        if (CNT_W'(j_r) + CNT_W'(2) < n_r) begin
          j_nxt     = j_r + LANE_W'(1);
          state_nxt = S_DRAW;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (cnt_r < n_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cnt_r[LANE_W-1:0];
        end
        if (cnt_r != '0) begin
          res_nxt[cnt_m1[LANE_W-1:0]] = ram_rdata;
        end
        if (cnt_r == n_r) begin
          state_nxt = S_PUSH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_nxt        = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      trig_high_r  <= 1'b0;
      first_pend_r <= 1'b1;
      chan_r       <= CHAN_W'(8);
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      trig_high_r  <= trig_high_nxt;
      first_pend_r <= first_pend_nxt;
      chan_r       <= chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    r_r       <= r_nxt;
    tmp_r     <= tmp_nxt;
    shuffle_r <= shuffle_nxt;
    samp_r    <= samp_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

`include "triggered_channel_shuffle_assert.svh"

  `TCS_ASSERT_HOLDS(a_swap_index_range, (state_r == S_WRJ) || (state_r == S_WRK), (k_r >= j_r) && (CNT_W'(k_r) < n_r), "swap index outside j .. n-1")
  `TCS_ASSERT_NEXT(a_accept_dispatch, accept, (state_r == S_LOAD) || (state_r == S_READ), "accepted item did not start load or read-out")
  `TCS_ASSERT_HOLDS(a_ram_write_phase, ram_req.we, (state_r == S_LOAD) || (state_r == S_WRJ) || (state_r == S_WRK), "slot store written outside load or swap")
  `TCS_ASSERT_NEXT(a_push_lands, (state_r == S_PUSH) && (!out_tvalid_r || out_tready), out_tvalid_r && (state_r == S_IDLE), "pushed result not presented")

endmodule
